FILE: src/pim_pkg.sv
// Shared types, constants and square root step for the pair invariant mass block.
package pim_pkg;

  localparam int FIELD_W   = 31;  // input momentum field width
  localparam int SUM_W     = 32;  // summed momentum and energy width
  localparam int MASS_W    = 24;  // mass register width
  localparam int MSQ_W     = 48;  // squared mass width
  localparam int RAD_W     = 64;  // square root radicand width
  localparam int ROOT_W    = 32;  // square root result width
  localparam int CFG_IDX_W = 2;

  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES          = ROOT_W / SQRT_STEPS_PER_STAGE;

  localparam logic [CFG_IDX_W-1:0] REG_HEAVY_MASS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_MASS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MASS = 2'd2;

  localparam logic [MASS_W-1:0] HEAVY_MASS_RST  = 24'd1115683;
  localparam logic [MASS_W-1:0] LIGHT_MASS_RST  = 24'd497611;
  localparam logic [MASS_W-1:0] TARGET_MASS_RST = 24'd939565;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] res;
  } sqrt_st_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
  } sums_t;

  // one digit of the restoring square root; step 0 handles the top bit pair
  function automatic sqrt_st_t sqrt_step(sqrt_st_t cur, int unsigned step);
    logic [RAD_W-1:0] b;
    logic [RAD_W-1:0] trial;
    sqrt_st_t nxt;
    b = RAD_W'(1) << (2 * (ROOT_W - 1 - step));
    trial = cur.res + b;
    if (cur.rem >= trial) begin
      nxt.rem = cur.rem - trial;
      nxt.res = (cur.res >> 1) + b;
    end else begin
      nxt.rem = cur.rem;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

endpackage

FILE: src/pim_if.sv
// Item channels: momentum pair in, invariant mass result out.
interface pim_in_if import pim_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [FIELD_W-1:0] first_px;
  logic signed [FIELD_W-1:0] first_py;
  logic signed [FIELD_W-1:0] first_pz;
  logic signed [FIELD_W-1:0] second_px;
  logic signed [FIELD_W-1:0] second_py;
  logic signed [FIELD_W-1:0] second_pz;

  modport source(output valid, first_px, first_py, first_pz, second_px, second_py,
                 second_pz, input ready);
  modport sink(input valid, first_px, first_py, first_pz, second_px, second_py,
               second_pz, output ready);
endinterface

interface pim_out_if import pim_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SUM_W-1:0] sum_px;
  logic signed [SUM_W-1:0] sum_py;
  logic signed [SUM_W-1:0] sum_pz;
  logic [SUM_W-1:0]        total_energy;
  logic [ROOT_W-1:0]       mass_value;
  logic                    mass_sq_negative;

  modport source(output valid, sum_px, sum_py, sum_pz, total_energy, mass_value,
                 mass_sq_negative, input ready);
  modport sink(input valid, sum_px, sum_py, sum_pz, total_energy, mass_value,
               mass_sq_negative, output ready);
endinterface

FILE: src/pim_isqrt.sv
// Pipelined floor square root, two result bits per stage.
module pim_isqrt import pim_pkg::*; (
  input  logic              clk,
  input  logic              ce,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  sqrt_st_t st [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    sqrt_st_t stage_in;
    sqrt_st_t stage_out;

    if (s == 0) begin : g_first
      assign stage_in = '{rem: radicand, res: '0};
    end else begin : g_next
      assign stage_in = st[s-1];
    end

    always_comb begin
      stage_out = stage_in;
      for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
        stage_out = sqrt_step(stage_out, s * SQRT_STEPS_PER_STAGE + j);
      end
    end

    always_ff @(posedge clk) begin
      if (ce) st[s] <= stage_out;
    end
  end

  assign root = st[SQRT_STAGES-1].res[ROOT_W-1:0];

endmodule

FILE: src/pair_invariant_mass.sv
// Invariant mass of a heavy and a light particle striking a target at rest.
// One item enters per clock while the output is not stalled. Items pass through
// squaring and summing, a 16-stage square root for both energies, the forming of
// E^2 - p^2 and a 16-stage square root for the mass. The whole pipeline advances
// together: it holds, bubbles included, while a finished result waits at the
// output, and the input is not ready during that time. The user must write the
// mass registers only while no item is in flight; the block does not enforce it.
module pair_invariant_mass import pim_pkg::*; #(
  parameter int MOMENTUM_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASS_W-1:0]    cfg_data,
  pim_in_if.sink               pair_in,
  pim_out_if.source            mass_out
);

  localparam int ST_E     = 4 + SQRT_STAGES;       // energies out of the roots
  localparam int ST_DIFF  = ST_E + 3;              // mass squared magnitude
  localparam int LAST     = ST_DIFF + SQRT_STAGES; // result stage
  localparam int P2_DLY   = ST_E + 2 - 4;
  localparam int SUM_DLY  = LAST - 1;
  localparam int EOUT_DLY = LAST - (ST_E + 1);
  localparam int NEG_DLY  = LAST - ST_DIFF;

  logic [MASS_W-1:0] heavy_mass;
  logic [MASS_W-1:0] light_mass;
  logic [MASS_W-1:0] target_mass;

  always_ff @(posedge clk) begin
    if (rst) begin
      heavy_mass  <= HEAVY_MASS_RST;
      light_mass  <= LIGHT_MASS_RST;
      target_mass <= TARGET_MASS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEAVY_MASS:  heavy_mass  <= cfg_data;
        REG_LIGHT_MASS:  light_mass  <= cfg_data;
        REG_TARGET_MASS: target_mass <= cfg_data;
        default: ;
      endcase
    end
  end

  logic            ce;
  logic [LAST:1]   v;

  assign ce            = !v[LAST] || mass_out.ready;
  assign pair_in.ready = ce;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (ce) v <= {v[LAST-1:1], pair_in.valid};
  end

  // stage 1: sign extension, sums, magnitudes
  logic signed [SUM_W-1:0] a_in [3];
  logic signed [SUM_W-1:0] b_in [3];
  logic signed [SUM_W-1:0] s_in [3];
  sums_t                   sums;
  logic [FIELD_W-1:0]      a_abs [3];
  logic [FIELD_W-1:0]      b_abs [3];
  logic [SUM_W-1:0]        s_abs [3];

  always_comb begin
    a_in[0] = SUM_W'($signed(pair_in.first_px[MOMENTUM_BITS-1:0]));
    a_in[1] = SUM_W'($signed(pair_in.first_py[MOMENTUM_BITS-1:0]));
    a_in[2] = SUM_W'($signed(pair_in.first_pz[MOMENTUM_BITS-1:0]));
    b_in[0] = SUM_W'($signed(pair_in.second_px[MOMENTUM_BITS-1:0]));
    b_in[1] = SUM_W'($signed(pair_in.second_py[MOMENTUM_BITS-1:0]));
    b_in[2] = SUM_W'($signed(pair_in.second_pz[MOMENTUM_BITS-1:0]));
    for (int i = 0; i < 3; i++) s_in[i] = a_in[i] + b_in[i];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sums <= '{x: s_in[0], y: s_in[1], z: s_in[2]};
      for (int i = 0; i < 3; i++) begin
        a_abs[i] <= a_in[i][SUM_W-1] ? FIELD_W'(-a_in[i]) : FIELD_W'(a_in[i]);
        b_abs[i] <= b_in[i][SUM_W-1] ? FIELD_W'(-b_in[i]) : FIELD_W'(b_in[i]);
        s_abs[i] <= s_in[i][SUM_W-1] ? SUM_W'(-s_in[i]) : SUM_W'(s_in[i]);
      end
    end
  end

  // stage 2: squares
  logic [2*FIELD_W-2:0] a_sq [3];
  logic [2*FIELD_W-2:0] b_sq [3];
  logic [2*SUM_W-2:0]   s_sq [3];
  logic [MSQ_W-1:0]     hm_sq;
  logic [MSQ_W-1:0]     lm_sq;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        a_sq[i] <= (2*FIELD_W-1)'(a_abs[i] * a_abs[i]);
        b_sq[i] <= (2*FIELD_W-1)'(b_abs[i] * b_abs[i]);
        s_sq[i] <= (2*SUM_W-1)'(s_abs[i] * s_abs[i]);
      end
      hm_sq <= MSQ_W'(heavy_mass * heavy_mass);
      lm_sq <= MSQ_W'(light_mass * light_mass);
    end
  end

  // stages 3 and 4: adder tree
  logic [2*FIELD_W-1:0] ta1, ta2, tb1, tb2;
  logic [2*SUM_W-1:0]   tp1;
  logic [2*SUM_W-2:0]   tp2;
  logic [2*FIELD_W-1:0] n1, n2;
  logic [RAD_W-1:0]     p2;

  always_ff @(posedge clk) begin
    if (ce) begin
      ta1 <= (2*FIELD_W)'(a_sq[0]) + (2*FIELD_W)'(a_sq[1]);
      ta2 <= (2*FIELD_W)'(a_sq[2]) + (2*FIELD_W)'(hm_sq);
      tb1 <= (2*FIELD_W)'(b_sq[0]) + (2*FIELD_W)'(b_sq[1]);
      tb2 <= (2*FIELD_W)'(b_sq[2]) + (2*FIELD_W)'(lm_sq);
      tp1 <= (2*SUM_W)'(s_sq[0]) + (2*SUM_W)'(s_sq[1]);
      tp2 <= s_sq[2];
      n1  <= ta1 + ta2;
      n2  <= tb1 + tb2;
      p2  <= tp1 + RAD_W'(tp2);
    end
  end

  logic [ROOT_W-1:0] e1, e2;

  pim_isqrt u_root_heavy (.clk(clk), .ce(ce), .radicand(RAD_W'(n1)), .root(e1));
  pim_isqrt u_root_light (.clk(clk), .ce(ce), .radicand(RAD_W'(n2)), .root(e2));

  logic [RAD_W-1:0] p2_d [P2_DLY];

  always_ff @(posedge clk) begin
    if (ce) begin
      p2_d[0] <= p2;
      for (int i = 1; i < P2_DLY; i++) p2_d[i] <= p2_d[i-1];
    end
  end

  // energy, its square, and the signed mass squared
  logic [SUM_W-1:0] esum;
  logic [SUM_W-1:0] emag;
  logic [SUM_W-1:0] eout;
  logic [RAD_W-1:0] esq;
  logic [RAD_W-1:0] diff;
  logic             neg;

  assign esum = e1 + e2;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (esum >= SUM_W'(target_mass)) begin
        emag <= esum - SUM_W'(target_mass);
        eout <= esum - SUM_W'(target_mass);
      end else begin
        // energy below zero: report zero, keep the magnitude for the mass
        emag <= SUM_W'(target_mass) - esum;
        eout <= '0;
      end
      esq <= emag * emag;
      if (esq >= p2_d[P2_DLY-1]) begin
        diff <= esq - p2_d[P2_DLY-1];
        neg  <= 1'b0;
      end else begin
        diff <= p2_d[P2_DLY-1] - esq;
        neg  <= 1'b1;
      end
    end
  end

  logic [ROOT_W-1:0] mass;

  pim_isqrt u_root_mass (.clk(clk), .ce(ce), .radicand(diff), .root(mass));

  sums_t            sum_d  [SUM_DLY];
  logic [SUM_W-1:0] eout_d [EOUT_DLY];
  logic [NEG_DLY-1:0] neg_d;

  always_ff @(posedge clk) begin
    if (ce) begin
      sum_d[0]  <= sums;
      eout_d[0] <= eout;
      for (int i = 1; i < SUM_DLY; i++) sum_d[i] <= sum_d[i-1];
      for (int i = 1; i < EOUT_DLY; i++) eout_d[i] <= eout_d[i-1];
      neg_d <= {neg_d[NEG_DLY-2:0], neg};
    end
  end

  assign mass_out.valid            = v[LAST];
  assign mass_out.sum_px           = sum_d[SUM_DLY-1].x;
  assign mass_out.sum_py           = sum_d[SUM_DLY-1].y;
  assign mass_out.sum_pz           = sum_d[SUM_DLY-1].z;
  assign mass_out.total_energy     = eout_d[EOUT_DLY-1];
  assign mass_out.mass_value       = mass;
  assign mass_out.mass_sq_negative = neg_d[NEG_DLY-1];

endmodule

FILE: src/pim_checker.sv
// Port checks for the pair invariant mass block, bound to the top level.
module pim_checker import pim_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ROOT_W-1:0] mass_value,
  input logic [SUM_W-1:0]  total_energy
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a held result freezes the whole pipeline
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while result stalled");

  // a ready sink keeps the pipeline moving
  a_ready_flows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked with sink ready");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(mass_value) && $stable(total_energy))
    else $error("result changed while stalled");

endmodule

bind pair_invariant_mass pim_checker u_pim_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pair_in.ready),
  .out_valid    (mass_out.valid),
  .out_ready    (mass_out.ready),
  .mass_value   (mass_out.mass_value),
  .total_energy (mass_out.total_energy)
);

FILE: tb/tb_pair_invariant_mass.sv
// Testbench for pair_invariant_mass: directed and random momentum pairs against a predictor.
module tb_pair_invariant_mass;
  import pim_pkg::*;

  typedef struct {
    logic signed [FIELD_W-1:0] ax, ay, az, bx, by, bz;
  } pair_t;

  typedef struct {
    logic signed [SUM_W-1:0] sx, sy, sz;
    logic [SUM_W-1:0]        energy;
    logic [ROOT_W-1:0]       mass;
    logic                    spacelike;
  } mass_res_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASS_W-1:0] cfg_data = '0;

  pim_in_if  pair_in();
  pim_out_if mass_out();

  pair_invariant_mass dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pair_in(pair_in.sink), .mass_out(mass_out.source)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  logic [MASS_W-1:0] heavy_m, light_m, target_m;
  mass_res_t expected_q[$];
  int n_errors = 0;
  int n_sent = 0;
  int n_seen = 0;

  initial begin
    pair_in.valid = 0;
    pair_in.first_px = '0;
    pair_in.first_py = '0;
    pair_in.first_pz = '0;
    pair_in.second_px = '0;
    pair_in.second_py = '0;
    pair_in.second_pz = '0;
    mass_out.ready = 0;
  end

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag2(longint x, longint y, longint z);
    logic [63:0] ux, uy, uz;
    ux = x < 0 ? -x : x;
    uy = y < 0 ? -y : y;
    uz = z < 0 ? -z : z;
    return ux * ux + uy * uy + uz * uz;
  endfunction

  function automatic mass_res_t predict_mass(pair_t p);
    mass_res_t r;
    longint sx, sy, sz;
    logic [63:0] e1, e2, esum, emag, p2, esq, hm, lm, tm;
    hm = 64'(heavy_m);
    lm = 64'(light_m);
    tm = 64'(target_m);
    e1 = isqrt(mag2(longint'(p.ax), longint'(p.ay), longint'(p.az)) + hm * hm);
    e2 = isqrt(mag2(longint'(p.bx), longint'(p.by), longint'(p.bz)) + lm * lm);
    esum = e1 + e2;
    // energy below the target mass clamps to zero; the mass uses its magnitude
    if (esum >= tm) begin
      emag = esum - tm;
      r.energy = emag[31:0];
    end else begin
      emag = tm - esum;
      r.energy = '0;
    end
    sx = longint'(p.ax) + longint'(p.bx);
    sy = longint'(p.ay) + longint'(p.by);
    sz = longint'(p.az) + longint'(p.bz);
    p2 = mag2(sx, sy, sz);
    esq = emag * emag;
    r.spacelike = esq < p2;
    r.mass = r.spacelike ? ROOT_W'(isqrt(p2 - esq)) : ROOT_W'(isqrt(esq - p2));
    r.sx = sx[31:0];
    r.sy = sy[31:0];
    r.sz = sz[31:0];
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // valid stays high after an item so the next one can follow with no gap
  task automatic send_pair(pair_t p);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      pair_in.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    pair_in.valid <= 1;
    pair_in.first_px <= p.ax;
    pair_in.first_py <= p.ay;
    pair_in.first_pz <= p.az;
    pair_in.second_px <= p.bx;
    pair_in.second_py <= p.by;
    pair_in.second_pz <= p.bz;
    do @(posedge clk); while (!pair_in.ready);
    expected_q.insert(expected_q.size(), predict_mass(p));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    pair_in.valid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_mass(logic [CFG_IDX_W-1:0] idx, logic [MASS_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == REG_HEAVY_MASS) heavy_m = v;
    else if (idx == REG_LIGHT_MASS) light_m = v;
    else if (idx == REG_TARGET_MASS) target_m = v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_masses(logic [MASS_W-1:0] h, logic [MASS_W-1:0] l,
                            logic [MASS_W-1:0] t);
    drain();
    write_mass(REG_HEAVY_MASS, h);
    write_mass(REG_LIGHT_MASS, l);
    write_mass(REG_TARGET_MASS, t);
  endtask

  function automatic logic signed [FIELD_W-1:0] rand_mom();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return {1'b1, {(FIELD_W-1){1'b0}}};
    if (k == 1) return {1'b0, {(FIELD_W-1){1'b1}}};
    if (k < 5) return FIELD_W'($signed($urandom_range(0, 4000000)) - 2000000);
    return FIELD_W'($urandom);
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.ax = rand_mom(); p.ay = rand_mom(); p.az = rand_mom();
    p.bx = rand_mom(); p.by = rand_mom(); p.bz = rand_mom();
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    logic signed [FIELD_W-1:0] vals[6];
    vals = '{'0, 1, -1, {1'b1, {(FIELD_W-1){1'b0}}}, {1'b0, {(FIELD_W-1){1'b1}}}, 1000};
    foreach (vals[i]) begin
      p = '{vals[i], vals[i], vals[i], vals[i], vals[i], vals[i]};
      send_pair(p);
    end
    // back to back opposite momenta: timelike, pure rest energy
    p = '{12345, -777, 900000, -12345, 777, -900000};
    send_pair(p);
    p = '{{1'b1, {(FIELD_W-1){1'b0}}}, 0, 0, {1'b1, {(FIELD_W-1){1'b0}}}, 0, 0};
    send_pair(p);
    for (int i = 0; i < 6; i++) send_pair(rand_pair());
  endtask

  task automatic test_mass_settings();
    // zero masses, max target (negative energy), max masses, alternating bit patterns
    set_masses('0, '0, '0);
    send_pair('{0, 0, 0, 0, 0, 0});
    send_pair('{100, 0, 0, -50, 0, 0});
    set_masses('0, '0, '1);
    send_pair('{0, 0, 0, 0, 0, 0});
    send_pair('{3000, 4000, 0, 1, 2, 3});
    set_masses('1, '1, '0);
    for (int i = 0; i < 8; i++) send_pair(rand_pair());
    set_masses(24'hAAAAAA, 24'h555555, 24'h0F0F0F);
    for (int i = 0; i < 8; i++) send_pair(rand_pair());
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0)
        set_masses(24'($urandom), 24'($urandom), 24'($urandom_range(0, 3000000)));
      if (i == 500) drain();
      send_pair(rand_pair());
    end
  endtask

  always begin
    @(negedge clk);
    if ($urandom_range(0, 99) < 3) begin
      mass_out.ready <= 0;
      repeat ($urandom_range(10, 40)) @(negedge clk);
    end else begin
      mass_out.ready <= ($urandom_range(0, 99) < 70);
    end
  end

  always @(posedge clk) begin
    mass_res_t e;
    if (!rst && mass_out.valid && mass_out.ready) begin
      n_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (mass_out.sum_px !== e.sx) begin
          $error("sum_px exp %0d got %0d", e.sx, mass_out.sum_px); n_errors++;
        end
        if (mass_out.sum_py !== e.sy) begin
          $error("sum_py exp %0d got %0d", e.sy, mass_out.sum_py); n_errors++;
        end
        if (mass_out.sum_pz !== e.sz) begin
          $error("sum_pz exp %0d got %0d", e.sz, mass_out.sum_pz); n_errors++;
        end
        if (mass_out.total_energy !== e.energy) begin
          $error("total_energy exp %0d got %0d", e.energy, mass_out.total_energy);
          n_errors++;
        end
        if (mass_out.mass_value !== e.mass) begin
          $error("mass_value exp %0d got %0d", e.mass, mass_out.mass_value); n_errors++;
        end
        if (mass_out.mass_sq_negative !== e.spacelike) begin
          $error("mass_sq_negative exp %0b got %0b", e.spacelike,
                 mass_out.mass_sq_negative);
          n_errors++;
        end
      end
    end
  end

  initial begin
    heavy_m = HEAVY_MASS_RST;
    light_m = LIGHT_MASS_RST;
    target_m = TARGET_MASS_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_mass_settings();
    test_random(1000);
    drain();
    $display("sent %0d pairs, checked %0d results over several mass settings", n_sent,
             n_seen);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
src/pim_pkg.sv
src/pim_if.sv
src/pim_isqrt.sv
src/pair_invariant_mass.sv
src/pim_checker.sv
tb/tb_pair_invariant_mass.sv
